// ----- rtl/l1s_pkg.sv -----
// Shared types and constants for the L1 similarity scorer.
// No dependencies; imported by every other file of the block.
package l1s_pkg;

  localparam int ID_W        = 32;
  localparam int SUM_W       = 32;
  localparam int SCORE_W     = 20;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SCORE_W-1:0] SCORE_SCALE = SCORE_W'(1000000);

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_CMP,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic valid;
    logic cand;
    logic first;
    logic hit;
    logic last;
  } s1_ctrl_t;

endpackage

// ----- rtl/l1s_front.sv -----
// Front end: accepts items, holds the query store and accumulates |q - c|.
// Pushes one job per finished candidate into the queue. Uses l1s_pkg.
module l1s_front import l1s_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int VALUE_BITS = 16,
  parameter int LEN_W      = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  logic                          in_last,
  input  logic [ID_W-1:0]               in_candidate_id,
  output logic                          job_push,
  output logic [ID_W+SUM_W+2*LEN_W:0]   job_data,
  input  logic                          q_full,
  input  logic                          q_almost_full
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [LEN_W-1:0] DIM_MAX = LEN_W'(MAX_DIM);

  logic signed [VALUE_BITS-1:0] mem [MAX_DIM];
  logic signed [VALUE_BITS-1:0] rd_data_r;

  logic [LEN_W-1:0] qlen_r, qlen_nxt;
  logic             qopen_r, qopen_nxt;
  logic             qclip_r, qclip_nxt;
  logic [LEN_W-1:0] ccount_r, ccount_nxt;
  logic             cclip_r, cclip_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  s1_ctrl_t                     s1_r, s1_nxt;
  logic signed [VALUE_BITS-1:0] s1_value_r;
  logic [ID_W-1:0]              s1_id_r;
  logic [LEN_W-1:0]             s1_q_r, s1_q_nxt;
  logic [LEN_W-1:0]             s1_c_r, s1_c_nxt;
  logic                         s1_clip_r, s1_clip_nxt;

  logic             accept;
  logic             qstart;
  logic [LEN_W-1:0] qlen_eff;
  logic             wr_en;
  logic             rd_en;
  logic             cnt_ok;
  logic [LEN_W-1:0] cnt_new;
  logic             clip_new;

  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]        abs_diff;
  logic [SUM_W-1:0]           base;
  logic [SUM_W:0]             total;
  logic [SUM_W-1:0]           sum_new;

  assign job_push = s1_r.valid & s1_r.cand & s1_r.last;
  assign in_ready = job_push ? ~q_almost_full : ~q_full;
  assign accept   = in_valid & in_ready;

  assign qstart   = ~in_op & ~qopen_r;
  assign qlen_eff = qstart ? '0 : qlen_r;
  assign wr_en    = accept & ~in_op & (qlen_eff < DIM_MAX);
  assign cnt_ok   = ccount_r < DIM_MAX;
  assign rd_en    = accept & in_op & cnt_ok;
  assign cnt_new  = cnt_ok ? ccount_r + LEN_W'(1) : ccount_r;
  assign clip_new = cclip_r | ~cnt_ok;

  always_comb begin
    qlen_nxt    = qlen_r;
    qopen_nxt   = qopen_r;
    qclip_nxt   = qclip_r;
    ccount_nxt  = ccount_r;
    cclip_nxt   = cclip_r;
    s1_nxt      = '0;
    s1_q_nxt    = qlen_r;
    s1_c_nxt    = cnt_new;
    s1_clip_nxt = qclip_r | clip_new;
    if (accept && !in_op) begin
      qopen_nxt  = ~in_last;
      qlen_nxt   = wr_en ? qlen_eff + LEN_W'(1) : qlen_eff;
      qclip_nxt  = (qclip_r & ~qstart) | ~wr_en;
      ccount_nxt = qstart ? '0 : ccount_r;
      cclip_nxt  = cclip_r & ~qstart;
    end else if (accept) begin
      qopen_nxt   = 1'b0;
      ccount_nxt  = in_last ? '0 : cnt_new;
      cclip_nxt   = in_last ? 1'b0 : clip_new;
      s1_nxt.valid = 1'b1;
      s1_nxt.cand  = 1'b1;
      s1_nxt.first = ccount_r == '0;
      s1_nxt.hit   = cnt_ok & (ccount_r < qlen_r);
      s1_nxt.last  = in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[qlen_eff[AW-1:0]] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[ccount_r[AW-1:0]];
    end
  end

  assign diff     = {rd_data_r[VALUE_BITS-1], rd_data_r} - {s1_value_r[VALUE_BITS-1], s1_value_r};
  assign abs_diff = diff[VALUE_BITS] ? (VALUE_BITS+1)'(1) + (VALUE_BITS+1)'(~diff) : diff;
  assign base     = s1_r.first ? '0 : sum_r;
  assign total    = {1'b0, base} + (s1_r.hit ? (SUM_W+1)'(abs_diff) : '0);
  assign sum_new  = total[SUM_W] ? '1 : total[SUM_W-1:0];
  assign sum_nxt  = (s1_r.valid && s1_r.cand) ? sum_new : sum_r;

  assign job_data = {s1_id_r, sum_new, s1_q_r, s1_c_r, s1_clip_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r   <= '0;
      qopen_r  <= 1'b0;
      qclip_r  <= 1'b0;
      ccount_r <= '0;
      cclip_r  <= 1'b0;
      sum_r    <= '0;
      s1_r     <= '0;
    end else begin
      qlen_r   <= qlen_nxt;
      qopen_r  <= qopen_nxt;
      qclip_r  <= qclip_nxt;
      ccount_r <= ccount_nxt;
      cclip_r  <= cclip_nxt;
      sum_r    <= sum_nxt;
      s1_r     <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_value;
      s1_id_r    <= in_candidate_id;
      s1_q_r     <= s1_q_nxt;
      s1_c_r     <= s1_c_nxt;
      s1_clip_r  <= s1_clip_nxt;
    end
  end

endmodule

// ----- rtl/l1s_queue.sv -----
// Short job queue between front end and scoring back end.
// Register array with read and write pointers. Uses l1s_pkg.
module l1s_queue import l1s_pkg::*; #(
  parameter int W = 59
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         almost_full,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full        = count_r == CW'(QUEUE_DEPTH);
  assign almost_full = count_r >= CW'(QUEUE_DEPTH - 1);
  assign pop_valid   = count_r != '0;
  assign pop_data    = entry_r[rd_ptr_r];
  assign do_push     = push & ~full;
  assign do_pop      = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/l1s_back.sv -----
// Scoring back end: forms numerator and denominator, scales by shift-add
// and divides by restoring division, one bit a cycle. Uses l1s_pkg.
module l1s_back import l1s_pkg::*; #(
  parameter int LEN_W     = 13,
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_valid,
  output logic                        job_pop,
  input  logic [ID_W+SUM_W+2*LEN_W:0] job_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ID_W-1:0]             out_result_id,
  output logic [SCORE_W-1:0]          out_score,
  output logic                        out_length_clipped
);

  localparam int T_W   = SUM_W + 5;
  localparam int D_W   = LEN_W + FRAC_BITS;
  localparam int NUM_W = ((T_W > D_W) ? T_W : D_W) + 1;
  localparam int DEN_W = LEN_W + 5 + FRAC_BITS;
  localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int X_W   = DEN_W + SCORE_W;
  localparam int STEP_W = $clog2(SCORE_W);

  back_state_t state_r, state_nxt;

  logic [ID_W-1:0]    id_r, id_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [LEN_W-1:0]   q_r, q_nxt;
  logic [LEN_W-1:0]   c_r, c_nxt;
  logic               clip_r, clip_nxt;
  logic [NUM_W-1:0]   num_r, num_nxt;
  logic [DEN_W-1:0]   den_r, den_nxt;
  logic               zero_r, zero_nxt;
  logic [X_W-1:0]     acc_r, acc_nxt;
  logic [X_W-1:0]     mc_r, mc_nxt;
  logic [X_W-1:0]     dsh_r, dsh_nxt;
  logic [SCORE_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic [LEN_W-1:0] n_len, d_len;
  logic             ge;
  logic             last_step;

  assign n_len     = (q_r < c_r) ? q_r : c_r;
  assign d_len     = (q_r > c_r) ? q_r - c_r : c_r - q_r;
  assign ge        = acc_r >= dsh_r;
  assign last_step = step_r == STEP_W'(SCORE_W - 1);

  assign job_pop            = (state_r == B_IDLE) & job_valid;
  assign out_valid          = state_r == B_DONE;
  assign out_result_id      = id_r;
  assign out_score          = quo_r;
  assign out_length_clipped = clip_r;

  always_comb begin
    state_nxt = state_r;
    id_nxt    = id_r;
    sum_nxt   = sum_r;
    q_nxt     = q_r;
    c_nxt     = c_r;
    clip_nxt  = clip_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    zero_nxt  = zero_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    unique case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          {id_nxt, sum_nxt, q_nxt, c_nxt, clip_nxt} = job_data;
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        num_nxt  = NUM_W'({sum_r, 4'b0}) + NUM_W'({sum_r, 2'b0})
                 + NUM_W'({d_len, FRAC_BITS'(0)});
        den_nxt  = DEN_W'({n_len, 4'b0, FRAC_BITS'(0)})
                 + DEN_W'({n_len, 2'b0, FRAC_BITS'(0)});
        zero_nxt = (q_r == '0) | (c_r == '0);
        state_nxt = B_CMP;
      end
      B_CMP: begin
        if (zero_r || CMP_W'(num_r) >= CMP_W'(den_r)) begin
          quo_nxt   = '0;
          state_nxt = B_DONE;
        end else begin
          mc_nxt    = X_W'(CMP_W'(den_r) - CMP_W'(num_r));
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        if (SCORE_SCALE[step_r]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt   = mc_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (last_step) begin
          dsh_nxt   = X_W'(den_r) << (SCORE_W - 1);
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (ge) begin
          acc_nxt = acc_r - dsh_r;
        end
        quo_nxt  = {quo_r[SCORE_W-2:0], ge};
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r + STEP_W'(1);
        if (last_step) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    c_r    <= c_nxt;
    clip_r <= clip_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

endmodule

// ----- rtl/l1_similarity_scorer.sv -----
// L1 similarity scorer top level: front end, job queue and scoring back end.
// Input items are taken one per cycle while the four-entry job queue has room.
// A score is valid after the front-end register stage, the queue and the back end's idle, load,
// compare, multiply and divide states (a zero score goes from compare straight to done); one candidate at a time.
// Reset clears counters, flags, queue and back end; the query store is not
// cleared and is only used below the loaded query length. Uses l1s_pkg.
module l1_similarity_scorer import l1s_pkg::*; #(
  parameter int MAX_DIM    = 4096,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  input  logic [ID_W-1:0]              in_candidate_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ID_W-1:0]              out_result_id,
  output logic [SCORE_W-1:0]           out_score,
  output logic                         out_length_clipped
);

  localparam int LEN_W = $clog2(MAX_DIM + 1);
  localparam int JOB_W = ID_W + SUM_W + 2 * LEN_W + 1;

  logic             job_push;
  logic [JOB_W-1:0] job_in;
  logic             q_full;
  logic             q_almost_full;
  logic             job_valid;
  logic             job_pop;
  logic [JOB_W-1:0] job_out;

  l1s_front #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS),
    .LEN_W      (LEN_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_last         (in_last),
    .in_candidate_id (in_candidate_id),
    .job_push        (job_push),
    .job_data        (job_in),
    .q_full          (q_full),
    .q_almost_full   (q_almost_full)
  );

  l1s_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (job_push),
    .push_data   (job_in),
    .full        (q_full),
    .almost_full (q_almost_full),
    .pop_valid   (job_valid),
    .pop         (job_pop),
    .pop_data    (job_out)
  );

  l1s_back #(
    .LEN_W     (LEN_W),
    .FRAC_BITS (VALUE_BITS - 2)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (job_valid),
    .job_pop            (job_pop),
    .job_data           (job_out),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_id      (out_result_id),
    .out_score          (out_score),
    .out_length_clipped (out_length_clipped)
  );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for l1_similarity_scorer: directed and random item streams.
// Carries its own scoring model and compares every result field by field, in order.
// Depends on rtl/l1s_pkg.sv and rtl/l1_similarity_scorer.sv.
module tb_top;
  import l1s_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int FRAC_BITS    = 14;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CALM_ITEMS   = 880;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_CAND  = 1'b1
  } elem_op_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic               clipped;
  } score_rec_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = 1'b0;
  logic signed [15:0]  in_value = '0;
  logic                in_last = 1'b0;
  logic [ID_W-1:0]     in_candidate_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     out_result_id;
  logic [SCORE_W-1:0]  out_score;
  logic                out_length_clipped;

  l1_similarity_scorer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_value           (in_value),
    .in_last            (in_last),
    .in_candidate_id    (in_candidate_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_id      (out_result_id),
    .out_score          (out_score),
    .out_length_clipped (out_length_clipped)
  );

  logic signed [15:0] qstore [MAX_DIM];
  int unsigned        qlen = 0;
  int unsigned        ccount = 0;
  bit                 qopen = 1'b0;
  bit                 qclip = 1'b0;
  bit                 cclip = 1'b0;
  longint unsigned    l1_sum = 0;
  score_rec_t         pending_scores [$];

  logic signed [15:0] sent_query [0:MAX_DIM+103];
  int                 sent_qlen = 0;
  int                 items_sent = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [SCORE_W-1:0] similarity_score();
    longint unsigned n, d, num, den;
    logic [SCORE_W-1:0] s;
    s = '0;
    if (qlen != 0 && ccount != 0) begin
      n   = (qlen < ccount) ? qlen : ccount;
      d   = (qlen > ccount) ? qlen - ccount : ccount - qlen;
      num = 64'd20 * l1_sum + (d << FRAC_BITS);
      den = (64'd20 << FRAC_BITS) * n;
      if (num < den)
        s = SCORE_W'((64'd1000000 * (den - num)) / den);
    end
    return s;
  endfunction

  function automatic void score_item(elem_op_t op, logic signed [15:0] v, logic lst,
                                     logic [ID_W-1:0] id);
    int         a, diff;
    score_rec_t rec;
    if (op == OP_QUERY) begin
      if (!qopen) begin
        qopen  = 1'b1;
        qlen   = 0;
        qclip  = 1'b0;
        ccount = 0;
        l1_sum = 0;
        cclip  = 1'b0;
      end
      if (qlen < MAX_DIM) begin
        qstore[qlen] = v;
        qlen++;
      end else begin
        qclip = 1'b1;
      end
      if (lst)
        qopen = 1'b0;
    end else begin
      qopen = 1'b0;
      if (ccount < MAX_DIM) begin
        if (ccount < qlen) begin
          a    = int'(qstore[ccount]);
          diff = a - int'(v);
          if (diff < 0)
            diff = -diff;
          l1_sum += 64'(diff);
          if (l1_sum > 64'hFFFF_FFFF)
            l1_sum = 64'hFFFF_FFFF;
        end
        ccount++;
      end else begin
        cclip = 1'b1;
      end
      if (lst) begin
        rec.id      = id;
        rec.score   = similarity_score();
        rec.clipped = qclip | cclip;
        pending_scores.insert(pending_scores.size(), rec);
        ccount = 0;
        l1_sum = 0;
        cclip  = 1'b0;
      end
    end
  endfunction

  function automatic int idle_gap();
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 16);
    return gap;
  endfunction

  function automatic int pick_spread();
    int s;
    case ($urandom_range(0, 3))
      0: s = 0;
      1: s = 63;
      2: s = 2047;
      default: s = -1;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 40)
      $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_item(elem_op_t op, logic signed [15:0] v, logic lst,
                           logic [ID_W-1:0] id);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_value        <= v;
    in_last         <= lst;
    in_candidate_id <= id;
    do @(posedge clk); while (!in_ready);
    score_item(op, v, lst, id);
    items_sent++;
  endtask

  task automatic send_vector(elem_op_t op, int len, int spread, bit close,
                             logic [ID_W-1:0] id);
    logic signed [15:0] v;
    int                 i, delta;
    for (i = 0; i < len; i++) begin
      if (op == OP_QUERY) begin
        v = 16'($urandom);
        sent_query[i] = v;
      end else if (i < sent_qlen && spread >= 0) begin
        delta = (spread == 0) ? 0 : int'($urandom_range(0, 2 * spread)) - spread;
        v     = 16'(int'(sent_query[i]) + delta);
      end else begin
        v = 16'($urandom);
      end
      send_item(op, v, close && (i == len - 1), id);
    end
    if (op == OP_QUERY)
      sent_qlen = len;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    score_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch($sformatf("result id %h with no score pending", out_result_id));
      end else begin
        want = pending_scores.pop_front();
        if (out_result_id !== want.id)
          report_mismatch($sformatf("result_id %h, want %h", out_result_id, want.id));
        if (out_score !== want.score)
          report_mismatch($sformatf("score %0d, want %0d (id %h)", out_score, want.score,
                                    want.id));
        if (out_length_clipped !== want.clipped)
          report_mismatch($sformatf("length_clipped %b, want %b (id %h)",
                                    out_length_clipped, want.clipped, want.id));
      end
    end
  end

  task automatic test_no_query();
    send_item(OP_CAND, 16'sh1234, 1'b0, 32'h0000_0000);
    send_item(OP_CAND, 16'shFFFF, 1'b1, 32'hA5A5_5A5A);
    send_item(OP_CAND, 16'sh0000, 1'b1, 32'h0000_0001);
  endtask

  task automatic test_value_extremes();
    send_item(OP_QUERY, 16'sh7FFF, 1'b0, 32'h0);
    send_item(OP_QUERY, 16'sh8000, 1'b0, 32'h0);
    send_item(OP_QUERY, 16'sh0000, 1'b1, 32'h0);
    send_item(OP_CAND, 16'sh8000, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_CAND, 16'sh7FFF, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_CAND, 16'sh0000, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CAND, 16'sh7FFF, 1'b0, 32'h0);
    send_item(OP_CAND, 16'sh8000, 1'b0, 32'h0);
    send_item(OP_CAND, 16'sh0000, 1'b1, 32'h0);
    send_item(OP_CAND, 16'sh7FFF, 1'b0, 32'h5A5A_A5A5);
    send_item(OP_CAND, 16'sh8000, 1'b0, 32'h5A5A_A5A5);
    send_item(OP_CAND, 16'sh4000, 1'b1, 32'h5A5A_A5A5);
  endtask

  task automatic test_length_mismatch();
    send_item(OP_QUERY, 16'sh4000, 1'b0, 32'h0);
    send_item(OP_QUERY, 16'shC000, 1'b1, 32'h0);
    send_item(OP_CAND, 16'sh4000, 1'b0, 32'h0000_0010);
    send_item(OP_CAND, 16'shC000, 1'b0, 32'h0000_0010);
    send_item(OP_CAND, 16'sh1111, 1'b0, 32'h0000_0010);
    send_item(OP_CAND, 16'sh2222, 1'b1, 32'h0000_0010);
    send_item(OP_CAND, 16'sh4000, 1'b1, 32'h0000_0011);
  endtask

  task automatic test_interleaved_vectors();
    send_item(OP_QUERY, 16'sh0064, 1'b0, 32'h0);
    send_item(OP_QUERY, 16'sh00C8, 1'b0, 32'h0);
    send_item(OP_CAND, 16'sh0064, 1'b0, 32'h0000_0020);
    send_item(OP_CAND, 16'sh00C8, 1'b1, 32'h0000_0020);
    send_item(OP_CAND, 16'sh0007, 1'b0, 32'h0000_0021);
    send_item(OP_QUERY, 16'sh012C, 1'b1, 32'h0);
    send_item(OP_CAND, 16'sh012C, 1'b1, 32'h0000_0022);
  endtask

  task automatic test_random_stream();
    int start, kind, qn, cn;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_on = (items_sent - start < CALM_ITEMS) ? ($urandom_range(0, 3) != 0) : 1'b0;
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        qn = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        send_vector(OP_QUERY, qn, 0, 1'b1, $urandom);
        repeat ($urandom_range(1, 4)) begin
          cn = ($urandom_range(0, 2) == 0) ? $urandom_range(1, qn + 4) : qn;
          send_vector(OP_CAND, cn, pick_spread(), 1'b1, $urandom);
        end
      end else if (kind == 8) begin
        send_vector(OP_QUERY, $urandom_range(1, 6), 0, 1'b0, $urandom);
        send_vector(OP_CAND, $urandom_range(1, 8), pick_spread(), 1'b1, $urandom);
      end else begin
        send_vector(OP_CAND, $urandom_range(1, 3), -1, 1'b0, $urandom);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_no_query();
    test_value_extremes();
    test_length_mismatch();
    test_interleaved_vectors();
    test_random_stream();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
